// ----- sv/lfu_slot_replacement_core_macros.svh -----
// ----------------------------------------------------------------------------
// LFU slot replacement core: assertion macros
// Concurrent check wrappers, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LFU_SLOT_REPLACEMENT_CORE_MACROS_SVH
`define LFU_SLOT_REPLACEMENT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu_slot_replacement_core: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu_slot_replacement_core: next-cycle check failed");
`else
`define LFU_ASSERT_NOW(lbl, ante, cons)
`define LFU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU slot replacement package
// Widths, constants and the structs passed between cells and control.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int MAX_SLOTS = 32;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OCC_W     = $clog2(MAX_SLOTS + 1);
  localparam int KEY_W     = 8;
  localparam int CNT_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Search beat walking down the cell row, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [SLOT_W-1:0]  hit_idx;
    logic [CNT_W-1:0]   hit_count;
    logic               free;
    logic [SLOT_W-1:0]  free_idx;
    logic               best;
    logic [SLOT_W-1:0]  best_idx;
    logic [CNT_W-1:0]   best_count;
    logic [STAMP_W-1:0] best_stamp;
    logic [KEY_W-1:0]   best_key;
  } tok_t;

  // Slot update broadcast from control to every cell.
  typedef struct packed {
    logic               en;
    logic               fresh;
    logic [SLOT_W-1:0]  idx;
    logic [KEY_W-1:0]   key;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  // Registered result beat.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

// ----- sv/lfu_cell.sv -----
// ----------------------------------------------------------------------------
// LFU slot cell
// Holds one slot and folds it into the passing search beat.
// ----------------------------------------------------------------------------
module lfu_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lfu_pkg::SLOT_W-1:0] cell_idx,
  input  lfu_pkg::tok_t             tok_in,
  input  lfu_pkg::wr_t              wr,
  output lfu_pkg::tok_t             tok_out
);

  logic                        valid_r;
  logic [lfu_pkg::KEY_W-1:0]   key_r;
  logic [lfu_pkg::CNT_W-1:0]   cnt_r;
  logic [lfu_pkg::STAMP_W-1:0] stamp_r;
  lfu_pkg::tok_t               tok_r;
  lfu_pkg::tok_t               tok_nxt;
  logic                        wr_sel;

  assign wr_sel = wr.en && (wr.idx == cell_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (valid_r && !tok_in.hit && (key_r == tok_in.key)) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_idx   = cell_idx;
      tok_nxt.hit_count = cnt_r;
    end
    if (!valid_r && !tok_in.free) begin
      tok_nxt.free     = 1'b1;
      tok_nxt.free_idx = cell_idx;
    end
    // strict compares keep the lower slot on a full tie
    if (valid_r && (!tok_in.best || (cnt_r < tok_in.best_count) ||
        ((cnt_r == tok_in.best_count) && (stamp_r < tok_in.best_stamp)))) begin
      tok_nxt.best       = 1'b1;
      tok_nxt.best_idx   = cell_idx;
      tok_nxt.best_count = cnt_r;
      tok_nxt.best_stamp = stamp_r;
      tok_nxt.best_key   = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      key_r <= wr.key;
      cnt_r <= wr.count;
      if (wr.fresh) begin
        stamp_r <= wr.stamp;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- sv/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// LFU replacement control
// Decides hit, fill or evict from the finished search beat and tracks occupancy.
// ----------------------------------------------------------------------------
module lfu_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfu_pkg::tok_t               tail,
  input  logic [lfu_pkg::CFG_W-1:0]   frames,
  input  logic [lfu_pkg::STAMP_W-1:0] stamp,
  output lfu_pkg::wr_t                wr,
  output lfu_pkg::res_t               res,
  output logic [lfu_pkg::OCC_W-1:0]   occ
);

  logic [lfu_pkg::OCC_W-1:0] occ_r;
  logic [lfu_pkg::OCC_W-1:0] occ_nxt;
  logic [lfu_pkg::OCC_W-1:0] limit;
  lfu_pkg::res_t             res_r;
  lfu_pkg::res_t             res_nxt;

  // clamp the limit into 1..MAX_SLOTS
  always_comb begin
    if (frames == '0) begin
      limit = lfu_pkg::OCC_W'(1);
    end else if (frames > lfu_pkg::CFG_W'(lfu_pkg::MAX_SLOTS)) begin
      limit = lfu_pkg::OCC_W'(lfu_pkg::MAX_SLOTS);
    end else begin
      limit = lfu_pkg::OCC_W'(frames);
    end
  end

  always_comb begin
    occ_nxt          = occ_r;
    res_nxt          = '0;
    res_nxt.valid    = tail.valid;
    wr               = '0;
    wr.en            = tail.valid;
    wr.fresh         = 1'b1;
    wr.key           = tail.key;
    wr.count         = lfu_pkg::CNT_W'(1);
    wr.stamp         = stamp;
    priority if (tail.hit) begin
      wr.fresh     = 1'b0;
      wr.idx       = tail.hit_idx;
      wr.count     = (tail.hit_count == lfu_pkg::CNT_MAX) ? tail.hit_count
                                                          : tail.hit_count + 1'b1;
      res_nxt.hit  = 1'b1;
    end else if ((occ_r < limit) && tail.free) begin
      wr.idx  = tail.free_idx;
      occ_nxt = occ_r + 1'b1;
    end else if (tail.best) begin
      wr.idx           = tail.best_idx;
      res_nxt.ev_valid = 1'b1;
      res_nxt.ev_key   = tail.best_key;
    end else begin
      wr.idx  = '0;
      occ_nxt = occ_r + 1'b1;
    end
    res_nxt.slot  = wr.idx;
    res_nxt.count = wr.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      res_r.valid <= 1'b0;
    end else begin
      res_r <= res_nxt;
      if (tail.valid) begin
        occ_r <= occ_nxt;
      end
    end
  end

  assign res = res_r;
  assign occ = occ_r;

endmodule

// ----- sv/lfu_slot_replacement_core.sv -----
// ----------------------------------------------------------------------------
// LFU slot replacement core
// Least-frequently-used slot table with oldest-insertion tie-break.
// ----------------------------------------------------------------------------
// A key is accepted when start is high and busy is low. It walks down a row of
// 32 slot cells, one cell per cycle, gathering the first matching slot, the
// first free slot and the eviction victim (lowest count, then oldest stamp,
// then lowest slot). After the last cell, control updates the chosen slot and
// puts one result beat on the out_ ports for exactly one cycle, marked by
// out_valid; the receiver cannot stall, so take it then. Each access walks the
// key through every slot cell register and then the result register in control;
// busy drops in the cycle out_valid shows, so the next key can be accepted then.
// Write frames_in_use through cfg_we/cfg_wdata only while busy is low.
// ----------------------------------------------------------------------------
`include "lfu_slot_replacement_core_macros.svh"

module lfu_slot_replacement_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // access channel
  input  logic                      start,
  output logic                      busy,
  input  logic [lfu_pkg::KEY_W-1:0] in_candidate_key,
  // result channel
  output logic                      out_valid,
  output logic                      out_hit,
  output logic [lfu_pkg::SLOT_W-1:0] out_slot_index,
  output logic                      out_evicted_valid,
  output logic [lfu_pkg::KEY_W-1:0] out_evicted_key,
  output logic [lfu_pkg::CNT_W-1:0] out_new_count,
  // configuration
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);

  logic                        busy_r;
  logic                        accept;
  logic [lfu_pkg::CFG_W-1:0]   frames_r;
  logic [lfu_pkg::STAMP_W-1:0] seq_r;
  lfu_pkg::tok_t               tok_launch;
  lfu_pkg::tok_t               tok_chain [lfu_pkg::MAX_SLOTS+1];
  logic [lfu_pkg::MAX_SLOTS:0] tok_vld;
  lfu_pkg::wr_t                wr;
  lfu_pkg::res_t               res;
  logic [lfu_pkg::OCC_W-1:0]   occ;

  assign accept = start && !busy_r;

  // launch beat: only the key and valid matter, the rest starts empty
  always_comb begin
    tok_launch       = '0;
    tok_launch.valid = accept;
    tok_launch.key   = in_candidate_key;
  end

  assign tok_chain[0] = tok_launch;
  assign tok_vld[0]   = tok_launch.valid;

  for (genvar g = 0; g < lfu_pkg::MAX_SLOTS; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lfu_pkg::SLOT_W'(g)),
      .tok_in   (tok_chain[g]),
      .wr       (wr),
      .tok_out  (tok_chain[g+1])
    );
    assign tok_vld[g+1] = tok_chain[g+1].valid;
  end

  lfu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .tail   (tok_chain[lfu_pkg::MAX_SLOTS]),
    .frames (frames_r),
    .stamp  (seq_r),
    .wr     (wr),
    .res    (res),
    .occ    (occ)
  );

  // hold busy from accept until the beat leaves the last cell;
  // advance the stamp on every accepted key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      seq_r    <= '0;
      frames_r <= lfu_pkg::CFG_W'(lfu_pkg::MAX_SLOTS);
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        seq_r  <= seq_r + 1'b1;
      end else if (tok_chain[lfu_pkg::MAX_SLOTS].valid) begin
        busy_r <= 1'b0;
      end
      if (cfg_we) begin
        frames_r <= cfg_wdata;
      end
    end
  end

  assign busy              = busy_r;
  assign out_valid         = res.valid;
  assign out_hit           = res.hit;
  assign out_slot_index    = res.slot;
  assign out_evicted_valid = res.ev_valid;
  assign out_evicted_key   = res.ev_key;
  assign out_new_count     = res.count;

  `LFU_ASSERT_NOW(a_single_beat, 1'b1, $onehot0(tok_vld))
  `LFU_ASSERT_NOW(a_tail_busy, tok_vld[lfu_pkg::MAX_SLOTS], busy_r)
  `LFU_ASSERT_NEXT(a_accept_busy, accept, busy_r && tok_vld[1])
  `LFU_ASSERT_NOW(a_evict_miss, out_valid && out_evicted_valid, !out_hit)
  `LFU_ASSERT_NOW(a_occ_bound, 1'b1, occ <= lfu_pkg::OCC_W'(lfu_pkg::MAX_SLOTS))

endmodule
